/* rtl/assert_macros.svh */
// Assertion helpers shared by the checker's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define CFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence holds at the next clock edge.
`define CFC_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cfc_pkg.sv */
package cfc_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int MIN_FRAME = 6;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0] SYNC_RESET = 8'hA0;
    localparam logic [7:0] PROTOCOL_RESET = 8'h01;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC     = 2'd0,
        CFG_PROTOCOL = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT  = 2'd0,
        VERDICT_LEN_ERR = 2'd1,
        VERDICT_CRC_ERR = 2'd2,
        VERDICT_IGNORED = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        t_verdict    verdict;
        logic [7:0]  command;
        logic [15:0] crc_computed;
        logic [15:0] crc_received;
    } t_out_item;

    // Everything the back end needs to judge one finished frame.
    typedef struct packed {
        logic        header_good;
        logic        count_overflow;
        logic [7:0]  byte_count;
        logic [7:0]  length_field;
        logic [7:0]  command;
        logic [15:0] crc_acc;
        logic [15:0] crc_rx;
    } t_frame_sum;

endpackage

/* rtl/cfc_front.sv */
module cfc_front
    import cfc_pkg::*;
#(
    parameter int MAX_FRAME = 255
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_data,
    output logic                  o_in_stall,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_frame_sum            o_push_data
);

    localparam logic [7:0] MaxCount = 8'(MAX_FRAME);

    // Bitwise CRC-16/MODBUS update over one byte, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    logic [7:0]  r_sync, r_protocol;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_tail0, r_tail1;
    logic [7:0]  r_count, n_count;
    logic        r_ovf, n_ovf;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_cmd, n_cmd;
    logic        r_hg, n_hg;
    logic        w_accept;

    assign o_in_stall = i_q_full;
    assign w_accept = i_in_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
            r_protocol <= PROTOCOL_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SYNC:     r_sync <= i_cfg_data;
                CFG_PROTOCOL: r_protocol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_hg = r_hg;
        n_len = r_len;
        n_cmd = r_cmd;
        if (!r_ovf) begin
            if (r_count == 8'd0 && i_in_data.rx_byte != r_sync) begin
                n_hg = 1'b0;
            end
            if (r_count == 8'd1) begin
                n_len = i_in_data.rx_byte;
            end
            if (r_count == 8'd2 && i_in_data.rx_byte != r_protocol) begin
                n_hg = 1'b0;
            end
            if (r_count == 8'd3) begin
                n_cmd = i_in_data.rx_byte;
            end
        end
        // The two newest bytes are held back; they may be the trailing CRC.
        n_crc = (r_count >= 8'd2) ? crc_byte(r_crc, r_tail0) : r_crc;
        if (r_count >= MaxCount) begin
            n_ovf = 1'b1;
            n_count = r_count;
        end else begin
            n_ovf = r_ovf;
            n_count = r_count + 8'd1;
        end
    end

    assign o_push = w_accept && i_in_data.frame_end;
    assign o_push_data = '{
        header_good:    n_hg,
        count_overflow: n_ovf,
        byte_count:     n_count,
        length_field:   n_len,
        command:        n_cmd,
        crc_acc:        n_crc,
        crc_rx:         {r_tail1, i_in_data.rx_byte}
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_crc <= CRC_INIT;
            r_tail0 <= 8'd0;
            r_tail1 <= 8'd0;
            r_count <= 8'd0;
            r_ovf <= 1'b0;
            r_len <= 8'd0;
            r_cmd <= 8'd0;
            r_hg <= 1'b1;
        end else if (w_accept) begin
            r_crc <= n_crc;
            r_tail0 <= r_tail1;
            r_tail1 <= i_in_data.rx_byte;
            r_count <= n_count;
            r_ovf <= n_ovf;
            r_len <= n_len;
            r_cmd <= n_cmd;
            r_hg <= n_hg;
        end
    end

`include "assert_macros.svh"

    `CFC_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, o_push, r_count == 8'd0 && r_crc == CRC_INIT, "frame state not cleared after frame end")
    `CFC_ASSERT(a_count_limit, i_clk, i_rst_n, r_count <= MaxCount, "byte count beyond frame limit")

endmodule

/* rtl/cfc_queue.sv */
module cfc_queue
    import cfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_sum i_push_data,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_head_valid,
    output t_frame_sum o_head
);

    t_frame_sum r_slot [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

`include "assert_macros.svh"

    `CFC_ASSERT(a_no_overrun, i_clk, i_rst_n, !(i_push && o_full), "push into full queue")
    `CFC_ASSERT(a_no_underrun, i_clk, i_rst_n, !(i_pop && !o_head_valid), "pop from empty queue")

endmodule

/* rtl/cfc_back.sv */
module cfc_back
    import cfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_frame_sum i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data
);

    logic      r_valid;
    t_out_item r_out;
    t_verdict  w_verdict;

    always_comb begin
        priority if (!i_head.header_good) begin
            w_verdict = VERDICT_IGNORED;
        end else if (i_head.count_overflow || i_head.byte_count < 8'(MIN_FRAME)
                     || i_head.length_field != i_head.byte_count) begin
            w_verdict = VERDICT_LEN_ERR;
        end else if (i_head.crc_acc != i_head.crc_rx) begin
            w_verdict = VERDICT_CRC_ERR;
        end else begin
            w_verdict = VERDICT_ACCEPT;
        end
    end

    assign o_pop = i_head_valid && (!r_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= '{
                verdict:      w_verdict,
                command:      i_head.command,
                crc_computed: i_head.crc_acc,
                crc_received: i_head.crc_rx
            };
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data = r_out;

`include "assert_macros.svh"

    `CFC_ASSERT_NEXT(a_fill_output, i_clk, i_rst_n, i_head_valid && !r_valid, r_valid, "pending verdict not moved to output")

endmodule

/* rtl/command_frame_checker_crc16.sv */
// Command frame checker with CRC-16/MODBUS.
// Input channel: one frame byte per transaction (i_in_valid, o_in_stall, i_in_data),
// with frame_end set on the last byte. A byte is taken at every edge where valid is
// high and stall is low, so bytes may arrive back to back at one per cycle.
// Output channel: one verdict transaction per frame (o_out_valid, i_out_stall,
// o_out_data) carrying the verdict, the command byte and both CRC values.
// Configuration: write sync_value (index 0) or protocol_value (index 1) through
// i_cfg_we, i_cfg_index and i_cfg_data while the block is idle; other indexes are dropped.
// The edge that takes the last byte writes the frame summary into the queue; the back end
// registers its verdict in the output register once that register is free. Throughput is
// one byte per cycle while o_in_stall is low; the byte-wide CRC update is the step that sets it.
// A two-entry queue of finished frame summaries sits between the byte front end and
// the verdict register, so a stall on the output holds o_out_valid and its data while
// the front end keeps taking bytes until the queue fills; only then is o_in_stall raised.
// Synchronous active-low reset restores the default sync and protocol values, clears
// the frame in progress and empties the queue and the output register.
module command_frame_checker_crc16
    import cfc_pkg::*;
#(
    parameter int MAX_FRAME = 255
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    logic       w_push, w_full, w_pop, w_head_valid;
    t_frame_sum w_push_data, w_head;

    // Front end: header checks, byte count, and the running CRC with its
    // two-byte hold-back for the trailing checksum.
    cfc_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Finished frames wait here so either side may stall on its own.
    cfc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_data  (w_push_data),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    // Back end: ranks the errors and holds the verdict for the receiver.
    cfc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

/* tb/command_frame_checker_crc16_tb.sv */
module command_frame_checker_crc16_tb;
    import cfc_pkg::*;

    // The block is built with the full frame limit so that the count saturates at
    // 255 and a frame of exactly 255 bytes can still be accepted.
    localparam int FRAME_LIMIT = 255;

    // Indexes past the register list; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // SETTLE_CYCLES idle cycles after the last expected verdict let the block settle.
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT = 300000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;

    command_frame_checker_crc16 #(
        .MAX_FRAME(FRAME_LIMIT)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the two configuration registers.
    logic [7:0]  sync_reg;
    logic [7:0]  proto_reg;

    // Shadow copy of the frame in progress, as the checker sees it.
    logic [15:0] run_crc;
    logic [7:0]  run_tail[2];
    logic [7:0]  run_count;
    logic        run_ovf;
    logic [7:0]  run_len;
    logic [7:0]  run_cmd;
    logic        run_hdr_ok;

    // Verdicts predicted for finished frames and not yet seen on the output.
    t_out_item   pending_verdicts[$];
    logic [7:0]  frame_buf[$];

    bit          idle_in_on = 1'b1;
    bit          out_stall_on = 1'b1;
    int          stall_left = 0;
    int          cycle_count = 0;
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    int          verdict_tally[4] = '{0, 0, 0, 0};

    // One step of the reflected CRC-16/MODBUS update, one bit at a time.
    function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic clear_frame_state();
        run_crc = CRC_INIT;
        run_tail[0] = 8'h00;
        run_tail[1] = 8'h00;
        run_count = 8'h00;
        run_ovf = 1'b0;
        run_len = 8'h00;
        run_cmd = 8'h00;
        run_hdr_ok = 1'b1;
    endtask

    // Advances the shadow frame by one accepted byte. On the last byte of a frame the
    // expected verdict is queued and the shadow frame starts over.
    task automatic predict_byte(input logic [7:0] b, input logic is_last);
        t_out_item   v;
        logic [15:0] rx;
        // Header bytes are only looked at while the count is still meaningful.
        if (!run_ovf) begin
            if (run_count == 8'd0 && b != sync_reg) run_hdr_ok = 1'b0;
            if (run_count == 8'd1) run_len = b;
            if (run_count == 8'd2 && b != proto_reg) run_hdr_ok = 1'b0;
            if (run_count == 8'd3) run_cmd = b;
        end
        // The CRC trails the input by two bytes, so the CRC field itself is never folded.
        if (run_count >= 8'd2) run_crc = crc16_fold(run_crc, run_tail[0]);
        run_tail[0] = run_tail[1];
        run_tail[1] = b;
        if (run_count >= FRAME_LIMIT) begin
            run_ovf = 1'b1;
        end else begin
            run_count = run_count + 8'd1;
        end
        if (is_last) begin
            rx = {run_tail[0], run_tail[1]};
            if (!run_hdr_ok) begin
                v.verdict = VERDICT_IGNORED;
            end else if (run_ovf || run_count < MIN_FRAME || run_len != run_count) begin
                v.verdict = VERDICT_LEN_ERR;
            end else if (run_crc != rx) begin
                v.verdict = VERDICT_CRC_ERR;
            end else begin
                v.verdict = VERDICT_ACCEPT;
            end
            v.command = run_cmd;
            v.crc_computed = run_crc;
            v.crc_received = rx;
            pending_verdicts.push_back(v);
            frames_sent++;
            clear_frame_state();
        end
    endtask

    // Offers one byte on the input channel and returns at the edge where the
    // transaction is taken. Valid stays high across back-to-back bytes; when a gap
    // is inserted it is lowered first and raised again at a later edge.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        int r;
        gap = 0;
        if (idle_in_on) begin
            r = $urandom_range(0, 99);
            if (r >= 90) begin
                gap = $urandom_range(5, 20);
            end else if (r >= 60) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{rx_byte: b, frame_end: is_last};
        do @(posedge i_clk); while (o_in_stall);
        predict_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) begin
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    // Rewrites the last two bytes with the CRC of everything before them.
    task automatic seal_crc();
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = 0; i < frame_buf.size() - 2; i++) begin
            c = crc16_fold(c, frame_buf[i]);
        end
        frame_buf[frame_buf.size() - 2] = c[15:8];
        frame_buf[frame_buf.size() - 1] = c[7:0];
    endtask

    // A well-formed frame for the current settings; len must be at least six.
    task automatic build_frame(input int len, input logic [7:0] cmd);
        frame_buf.delete();
        frame_buf.push_back(sync_reg);
        frame_buf.push_back(8'(len));
        frame_buf.push_back(proto_reg);
        frame_buf.push_back(cmd);
        for (int i = 4; i < len; i++) begin
            frame_buf.push_back(8'($urandom));
        end
        seal_crc();
    endtask

    task automatic build_noise(input int len);
        frame_buf.delete();
        repeat (len) frame_buf.push_back(8'($urandom));
    endtask

    // Stops sending and waits until every predicted verdict has been taken, then
    // lets the block settle so that nothing is in flight.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One write per edge; the enable is left high so that writes can follow each
    // other, and apply_config lowers it after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_SYNC:     sync_reg = val;
            CFG_PROTOCOL: proto_reg = val;
            default:      ;
        endcase
    endtask

    task automatic apply_config(input logic [7:0] sync_v, input logic [7:0] proto_v,
                                input bit touch_spare);
        wait_drained();
        write_reg(CFG_SYNC, sync_v);
        if (touch_spare) begin
            write_reg(CFG_SPARE_2, 8'($urandom));
            write_reg(CFG_SPARE_3, 8'($urandom));
        end
        write_reg(CFG_PROTOCOL, proto_v);
        i_cfg_we <= 1'b0;
    endtask

    // Back-pressure on the output: often none, otherwise mostly short stalls and now and then
    // a long one, and none at all once a running stall ends while a test has switched it off.
    always @(posedge i_clk) begin : out_stall_gen
        int r;
        if (stall_left > 0) begin
            stall_left--;
        end else if (!out_stall_on) begin
            i_out_stall <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                i_out_stall <= 1'b0;
                stall_left = $urandom_range(0, 4);
            end else if (r < 92) begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(8, 30);
            end
        end
    end

    // Every verdict transaction is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_verdicts
        t_out_item want;
        t_out_item got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = o_out_data;
            if (pending_verdicts.size() == 0) begin
                $error("verdict transaction with no frame outstanding: %h", got);
                mismatches++;
            end else begin
                want = pending_verdicts.pop_front();
                verdict_tally[want.verdict]++;
                if (got.verdict !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                    mismatches++;
                end
                if (got.command !== want.command) begin
                    $error("command: expected %h, got %h", want.command, got.command);
                    mismatches++;
                end
                if (got.crc_computed !== want.crc_computed) begin
                    $error("crc_computed: expected %h, got %h",
                           want.crc_computed, got.crc_computed);
                    mismatches++;
                end
                if (got.crc_received !== want.crc_received) begin
                    $error("crc_received: expected %h, got %h",
                           want.crc_received, got.crc_received);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) cycle_count++;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles with %0d verdicts outstanding.",
                 cycle_count, pending_verdicts.size());
        $display("status: fail");
        $finish;
    end

    // Short directed frames with the reset settings: the one-byte frame, whose
    // received CRC has an empty high half and whose computed CRC is the initial
    // value; a two-byte frame with only part of the header present; the shortest
    // good frame; a bad sync byte; and a corrupted CRC.
    task automatic test_directed();
        idle_in_on = 1'b0;
        out_stall_on = 1'b0;
        build_noise(1);
        frame_buf[0] = sync_reg;
        send_frame();
        build_noise(2);
        frame_buf[0] = sync_reg;
        frame_buf[1] = 8'h00;
        send_frame();
        build_frame(MIN_FRAME, 8'hFF);
        send_frame();
        build_frame(MIN_FRAME, 8'h00);
        frame_buf[0] = ~sync_reg;
        send_frame();
        build_frame(MIN_FRAME, 8'($urandom));
        frame_buf[MIN_FRAME - 1] ^= 8'h01;
        send_frame();
    endtask

    // Header and length checks: a bad protocol byte, a length byte that disagrees
    // with the count, a short frame whose length byte matches its count, a bad header
    // on a short frame, where the header verdict must win, and a good frame of seven bytes.
    task automatic test_header_and_length();
        idle_in_on = 1'b1;
        out_stall_on = 1'b1;
        build_frame(8, 8'h5A);
        frame_buf[2] = ~proto_reg;
        seal_crc();
        send_frame();
        build_frame(9, 8'hA5);
        frame_buf[1] = 8'd10;
        seal_crc();
        send_frame();
        build_noise(5);
        frame_buf[0] = sync_reg;
        frame_buf[1] = 8'd5;
        frame_buf[2] = proto_reg;
        send_frame();
        build_noise(4);
        frame_buf[0] = sync_reg ^ 8'h10;
        send_frame();
        build_frame(7, 8'h3C);
        send_frame();
    endtask

    // Several register settings, the extremes among them. The spare indexes are
    // written along the way and must leave both registers untouched.
    task automatic test_config_settings();
        logic [7:0] sync_set[3];
        logic [7:0] proto_set[3];
        sync_set = '{8'h00, 8'hFF, 8'($urandom)};
        proto_set = '{8'h00, 8'hFF, 8'($urandom)};
        for (int s = 0; s < 3; s++) begin
            apply_config(sync_set[s], proto_set[s], 1'b1);
            build_frame($urandom_range(6, 12), 8'($urandom));
            send_frame();
            build_frame(6, 8'($urandom));
            frame_buf[2] = proto_reg ^ 8'h80;
            seal_crc();
            send_frame();
            build_frame(6, 8'($urandom));
            frame_buf[0] = SYNC_RESET ^ ((sync_reg == SYNC_RESET) ? 8'h01 : 8'h00);
            send_frame();
        end
        apply_config(SYNC_RESET, PROTOCOL_RESET, 1'b0);
    endtask

    // A frame one byte past the limit saturates the count and must end as a length
    // error even with a good header and a sealed CRC, while the CRC keeps running.
    task automatic test_long_frames();
        build_frame(FRAME_LIMIT + 1, 8'($urandom));
        send_frame();
    endtask

    // Mostly well-formed frames with random content, mixed with broken ones and
    // noise, in phases that change the settings and the amount of idling.
    task automatic test_random_traffic();
        int start_bytes;
        int start_frames;
        int phase_end;
        int r;
        int len;
        logic [7:0] sync_v;
        logic [7:0] proto_v;
        start_bytes = bytes_sent;
        start_frames = frames_sent;
        while (bytes_sent - start_bytes < 120 || frames_sent - start_frames < 8) begin
            r = $urandom_range(0, 5);
            sync_v = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : (r == 2) ? SYNC_RESET
                                                         : 8'($urandom);
            r = $urandom_range(0, 5);
            proto_v = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : (r == 2) ? PROTOCOL_RESET
                                                          : 8'($urandom);
            apply_config(sync_v, proto_v, $urandom_range(0, 3) == 0);
            // Roughly one phase in four runs with no idling at all on either side.
            idle_in_on = $urandom_range(0, 3) != 0;
            out_stall_on = idle_in_on ? ($urandom_range(0, 4) != 0) : 1'b0;
            phase_end = bytes_sent + 40;
            while (bytes_sent < phase_end) begin
                r = $urandom_range(0, 99);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 64)
                                                  : $urandom_range(6, 20);
                build_frame(len, 8'($urandom));
                if (r < 65) begin
                    // Well-formed frame, left as built.
                end else if (r < 71) begin
                    frame_buf[0] ^= 8'($urandom_range(1, 255));
                end else if (r < 77) begin
                    frame_buf[2] ^= 8'($urandom_range(1, 255));
                    seal_crc();
                end else if (r < 84) begin
                    frame_buf[1] = 8'(len + $urandom_range(1, 255));
                    seal_crc();
                end else if (r < 90) begin
                    frame_buf[$urandom_range(3, len - 1)] ^= 8'($urandom_range(1, 255));
                end else if (r < 95) begin
                    build_noise($urandom_range(1, 5));
                    frame_buf[0] = sync_reg;
                end else begin
                    build_noise($urandom_range(1, 24));
                end
                send_frame();
            end
        end
    endtask

    initial begin
        sync_reg = SYNC_RESET;
        proto_reg = PROTOCOL_RESET;
        clear_frame_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_header_and_length();
        test_config_settings();
        test_long_frames();
        test_random_traffic();

        wait_drained();
        $display("Sent %0d bytes in %0d frames under several sync and protocol settings.",
                 bytes_sent, frames_sent);
        $display("Verdicts: %0d accepted, %0d length, %0d CRC, %0d ignored; %0d mismatches.",
                 verdict_tally[VERDICT_ACCEPT], verdict_tally[VERDICT_LEN_ERR],
                 verdict_tally[VERDICT_CRC_ERR], verdict_tally[VERDICT_IGNORED],
                 mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/cfc_pkg.sv
rtl/cfc_front.sv
rtl/cfc_queue.sv
rtl/cfc_back.sv
rtl/command_frame_checker_crc16.sv
tb/command_frame_checker_crc16_tb.sv
